// ----- rtl/core/gf128_ghash_multiply_defines.svh -----
// Assertion macros for the GHASH multiplier block.
// Depends on clk and rst_n being visible where a macro is used.
`ifndef GF128_GHASH_MULTIPLY_DEFINES_SVH
`define GF128_GHASH_MULTIPLY_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define GFGH_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define GFGH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/gfgh_pkg.sv -----
// Shared widths and constants for the GHASH GF(2^128) multiplier.
// No dependencies.
`timescale 1ns / 1ps

package gfgh_pkg;

    localparam int GF_BITS   = 128;
    localparam int HALF_BITS = GF_BITS / 2;
    localparam int PROD_BITS = 2 * GF_BITS - 1;

    // Low taps of x^128 + x^7 + x^2 + x + 1 (0xE1 in the reflected top byte).
    localparam int TAP_A = 1;
    localparam int TAP_B = 2;
    localparam int TAP_C = 7;
    // Width of the spill above bit 127 after the first fold.
    localparam int SPILL_BITS = TAP_C - 1;

    typedef logic [GF_BITS-1:0]   gf_elem_t;
    typedef logic [HALF_BITS-1:0] gf_half_t;
    typedef logic [PROD_BITS-1:0] gf_wide_t;

endpackage

// ----- rtl/core/gfgh_channels.sv -----
// Valid/ready channel interfaces for operand and product items.
// Depends on gfgh_pkg.
`timescale 1ns / 1ps

interface gfgh_operand_if import gfgh_pkg::*; ();
    logic     valid;
    logic     ready;
    gf_half_t x_high;
    gf_half_t x_low;
    gf_half_t key_high;
    gf_half_t key_low;

    modport source (output valid, x_high, x_low, key_high, key_low, input ready);
    modport sink   (input valid, x_high, x_low, key_high, key_low, output ready);
endinterface

interface gfgh_product_if import gfgh_pkg::*; ();
    logic     valid;
    logic     ready;
    gf_half_t product_high;
    gf_half_t product_low;

    modport source (output valid, product_high, product_low, input ready);
    modport sink   (input valid, product_high, product_low, output ready);
endinterface

// ----- rtl/core/gf128_ghash_multiply.sv -----
// GHASH GF(2^128) multiplier top level: operand register, multiply array, result register.
// Depends on gfgh_pkg, gfgh_channels, gfgh_clmul, gfgh_reduce and the defines header.
`timescale 1ns / 1ps
`include "gf128_ghash_multiply_defines.svh"

// Multiplies X by the hash key Y in GF(2^128) with the GCM bit convention
// (bit 127 of each operand is the x^0 coefficient, field polynomial
// x^128 + x^7 + x^2 + x + 1). An operand item carries X as x_high/x_low and
// Y as key_high/key_low; each item yields exactly one product item, in order.
// The block takes a new item every clock cycle unless the output stalls. An
// accepted item is held in the operand register, then passes through the
// carry-less AND-XOR array and two-level polynomial fold and is captured in the
// result register. The result register and the operand register both hold
// an item, so an item is still taken while an unread product waits; input
// ready follows output ready only when both registers are full. No
// configuration, no state between items; reset only clears the valid flags.

module gf128_ghash_multiply import gfgh_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    gfgh_operand_if.sink    operands,
    gfgh_product_if.source  result
);

    // Stage 1: operand register
    logic     op_valid_reg;
    logic     op_valid_next;
    gf_elem_t x_reg;
    gf_elem_t key_reg;

    // Stage 2: result register
    logic     res_valid_reg;
    logic     res_valid_next;
    gf_elem_t prod_reg;
    gf_elem_t prod_next;

    gf_wide_t coeff;

    logic res_free;
    logic op_advance;
    logic op_load;

    // Result slot is free when empty or being drained this cycle.
    assign res_free   = !res_valid_reg || result.ready;
    assign op_advance = op_valid_reg && res_free;
    assign operands.ready = !op_valid_reg || res_free;
    assign op_load    = operands.valid && operands.ready;

    assign op_valid_next  = op_load || (op_valid_reg && !op_advance);
    assign res_valid_next = op_advance || (res_valid_reg && !result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            op_valid_reg  <= op_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers, no reset.
    always_ff @(posedge clk)
    begin
        if (op_load)
        begin
            x_reg   <= {operands.x_high, operands.x_low};
            key_reg <= {operands.key_high, operands.key_low};
        end
        if (op_advance)
        begin
            prod_reg <= prod_next;
        end
    end

    // Multiply array between the two registers.
    gfgh_clmul u_clmul
    (
        .x     (x_reg),
        .key   (key_reg),
        .coeff (coeff)
    );

    gfgh_reduce u_reduce
    (
        .coeff (coeff),
        .z     (prod_next)
    );

    assign result.valid        = res_valid_reg;
    assign result.product_high = prod_reg[GF_BITS-1:HALF_BITS];
    assign result.product_low  = prod_reg[HALF_BITS-1:0];

    // Both stages full and output stalled: no room for another item.
    `GFGH_ASSERT_NOW(a_full_blocks_input, op_valid_reg && res_valid_reg && !result.ready, !operands.ready, "operand accepted with both stages full")

    // An item leaving stage 1 must show up as a valid product.
    `GFGH_ASSERT_NEXT(a_advance_fills_result, op_advance, res_valid_reg, "advanced item lost before result register")

    // A zero operand gives a zero product.
    `GFGH_ASSERT_NEXT(a_zero_operand, op_advance && (x_reg == '0 || key_reg == '0), result.product_high == '0 && result.product_low == '0, "nonzero product from zero operand")

endmodule

// ----- rtl/core/gfgh_clmul.sv -----
// Carry-less 128x128 multiply in polynomial (reflected) bit order.
// Depends on gfgh_pkg.
`timescale 1ns / 1ps

module gfgh_clmul import gfgh_pkg::*;
(
    input  gf_elem_t x,
    input  gf_elem_t key,
    output gf_wide_t coeff
);

    gf_elem_t a;
    gf_elem_t b;

    // GCM order: bit 127 of an operand is the x^0 coefficient.
    always_comb
    begin
        for (int j = 0; j < GF_BITS; j++)
        begin
            a[j] = x[GF_BITS-1-j];
            b[j] = key[GF_BITS-1-j];
        end
    end

    // Each product bit is an independent AND-XOR tree.
    always_comb
    begin
        coeff = '0;
        for (int i = 0; i < GF_BITS; i++)
        begin
            for (int j = 0; j < GF_BITS; j++)
            begin
                coeff[i+j] = coeff[i+j] ^ (a[i] & b[j]);
            end
        end
    end

endmodule

// ----- rtl/core/gfgh_reduce.sv -----
// Reduction mod x^128 + x^7 + x^2 + x + 1, result back in GCM bit order.
// Depends on gfgh_pkg.
`timescale 1ns / 1ps

module gfgh_reduce import gfgh_pkg::*;
(
    input  gf_wide_t coeff,
    output gf_elem_t z
);

    localparam int HI_BITS  = PROD_BITS - GF_BITS;
    localparam int MID_BITS = GF_BITS + SPILL_BITS;

    logic [HI_BITS-1:0]    hi;
    logic [MID_BITS-1:0]   fold1;
    logic [SPILL_BITS-1:0] spill;
    gf_elem_t              r;

    assign hi = coeff[PROD_BITS-1:GF_BITS];

    // First fold: x^128 -> x^7 + x^2 + x + 1, leaves a short spill.
    always_comb
    begin
        fold1 = MID_BITS'(coeff[GF_BITS-1:0])
              ^ MID_BITS'(hi)
              ^ (MID_BITS'(hi) << TAP_A)
              ^ (MID_BITS'(hi) << TAP_B)
              ^ (MID_BITS'(hi) << TAP_C);
    end

    assign spill = fold1[MID_BITS-1:GF_BITS];

    // Second fold of the spill never reaches bit 128.
    always_comb
    begin
        r = fold1[GF_BITS-1:0]
          ^ GF_BITS'(spill)
          ^ (GF_BITS'(spill) << TAP_A)
          ^ (GF_BITS'(spill) << TAP_B)
          ^ (GF_BITS'(spill) << TAP_C);
    end

    always_comb
    begin
        for (int j = 0; j < GF_BITS; j++)
        begin
            z[GF_BITS-1-j] = r[j];
        end
    end

endmodule
